// ===== rtl/nfa_to_dfa_subset_construction_top_defines.svh =====
// Assertion macros used by the sequencer RTL
`ifndef NFA_TO_DFA_SUBSET_CONSTRUCTION_TOP_DEFINES_SVH
`define NFA_TO_DFA_SUBSET_CONSTRUCTION_TOP_DEFINES_SVH

// a implies b in the same cycle
`define N2D_ASSERT_IMPL(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("%m: assertion failed");

// a implies b in the next cycle
`define N2D_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("%m: assertion failed");

`endif

// ===== rtl/n2d_pkg.sv =====
`timescale 1ns / 1ps
package n2d_pkg;
   localparam int NfaStates = 16;
   localparam int Symbols   = 4;
   localparam int DfaStates = 64;
   localparam int Cols      = Symbols + 1;
   localparam int EdgeDepth = NfaStates * Cols;
   localparam int NextDepth = DfaStates * Symbols;
   localparam int StW       = $clog2(NfaStates);
   localparam int SymW      = $clog2(Cols);
   localparam int EdgeAw    = $clog2(EdgeDepth);
   localparam int SetAw     = $clog2(DfaStates);
   localparam int NextAw    = $clog2(NextDepth);
   localparam int CntW      = SetAw + 1;

   localparam logic [1:0] CSR_START  = 2'd0;
   localparam logic [1:0] CSR_FINAL  = 2'd1;
   localparam logic [1:0] CSR_SYMCNT = 2'd2;

   typedef logic [NfaStates-1:0] mask_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_MOVE, ST_MOVE_WAIT, ST_CLOS_CHK, ST_FIND, ST_FIND_WAIT,
      ST_STORE, ST_NEXT_SYM, ST_EMIT_RD, ST_EMIT_WAIT, ST_EMIT
   } state_type;

   // request from the sequencer to the move/closure unit
   typedef struct packed {
      logic     start;
      mask_type set;
      logic [SymW-1:0] col;
      logic     closure;
   } mv_req_type;

   typedef struct packed {
      logic     done;
      mask_type result;
   } mv_rsp_type;
endpackage

// ===== rtl/n2d_if.sv =====
`timescale 1ns / 1ps
interface n2d_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [4:0] from_state;
   logic [2:0] symbol;
   logic [15:0] target_mask;
   modport source (output valid, op, from_state, symbol, target_mask, input ready);
   modport sink (input valid, op, from_state, symbol, target_mask, output ready);
endinterface

interface n2d_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] row_index;
   logic [15:0] member_mask;
   logic [6:0] next_sym0;
   logic [6:0] next_sym1;
   logic [6:0] next_sym2;
   logic [6:0] next_sym3;
   logic       is_final;
   logic       overflow;
   logic       last;
   modport source (output valid, row_index, member_mask, next_sym0, next_sym1, next_sym2,
                   next_sym3, is_final, overflow, last, input ready);
   modport sink (input valid, row_index, member_mask, next_sym0, next_sym1, next_sym2,
                 next_sym3, is_final, overflow, last, output ready);
endinterface

// ===== rtl/n2d_move.sv =====
`timescale 1ns / 1ps
// Move / closure unit: scans one NFA state per cycle through the edge memory.
module n2d_move
   import n2d_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  logic [EdgeAw-1:0] wr_addr,
   input  mask_type        wr_data,
   input  mv_req_type      req,
   output mv_rsp_type      rsp
);
   localparam int KW = $clog2(NfaStates + 1);

   mask_type edge_mem [EdgeDepth];
   logic [EdgeDepth-1:0] valid_ff;
   mask_type rd_data_ff;
   logic     rd_valid_ff, rd_valid_in;
   logic     busy_ff, busy_in;
   logic     clos_ff, clos_in;
   logic [SymW-1:0] col_ff, col_in;
   mask_type set_ff, set_in, acc_ff, acc_in;
   logic [KW-1:0] k_ff, k_in;
   logic [EdgeAw-1:0] rd_addr;
   logic     rd_en;
   logic     done_ff, done_in;

   always_ff @(posedge clock) begin
      if (wr_en) edge_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= edge_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         busy_ff <= busy_in;
         rd_valid_ff <= rd_valid_in;
         done_ff <= done_in;
      end
      clos_ff <= clos_in;
      col_ff <= col_in;
      set_ff <= set_in;
      acc_ff <= acc_in;
      k_ff <= k_in;
   end

   // entry mask applied with valid bit
   mask_type entry;
   logic [EdgeAw-1:0] rd_addr_q;
   always_ff @(posedge clock) begin
      if (rd_en) rd_addr_q <= rd_addr;
   end
   assign entry = valid_ff[rd_addr_q] ? rd_data_ff : '0;

   always_comb begin
      busy_in = busy_ff;
      clos_in = clos_ff;
      col_in = col_ff;
      set_in = set_ff;
      acc_in = acc_ff;
      k_in = k_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      rd_valid_in = 1'b0;
      done_in = 1'b0;
      if (!busy_ff) begin
         if (req.start) begin
            busy_in = 1'b1;
            clos_in = req.closure;
            col_in = req.closure ? SymW'(Symbols) : req.col;
            set_in = req.set;
            acc_in = req.closure ? req.set : '0;
            k_in = '0;
         end
      end else begin
         if (rd_valid_ff) acc_in = acc_ff | entry;
         if (k_ff < KW'(NfaStates)) begin
            if (set_ff[k_ff[StW-1:0]]) begin
               rd_en = 1'b1;
               rd_addr = EdgeAw'(k_ff[StW-1:0] * Cols + col_ff);
               rd_valid_in = 1'b1;
            end
            k_in = k_ff + 1'b1;
         end else if (!rd_valid_ff) begin
            if (clos_ff && acc_ff != set_ff) begin
               set_in = acc_ff;
               k_in = '0;
            end else begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.result = acc_ff;
endmodule

// ===== rtl/n2d_seq.sv =====
`timescale 1ns / 1ps
`include "nfa_to_dfa_subset_construction_top_defines.svh"
// Construction sequencer: worklist, set store search, next-state store, emit.
module n2d_seq
   import n2d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       run,
   output logic       busy,
   input  logic [4:0] start_state,
   input  mask_type   final_mask,
   input  logic [2:0] symbol_count,
   output mv_req_type mv_req,
   input  mv_rsp_type mv_rsp,
   n2d_rsp_if.source  rsp
);
   localparam int NW = CntW;

   state_type state_ff, state_in;
   state_type st_sel;
   mask_type  set_mem [DfaStates];
   logic [NW-1:0] next_mem [NextDepth];

   logic [CntW-1:0] cnt_ff, cnt_in, wp_ff, wp_in, fi_ff, fi_in;
   logic [SymW-1:0] c_ff, c_in, eff_ff, eff_in;
   logic ovf_ff, ovf_in, clos_ff, clos_in, phase_ff, phase_in;
   mask_type cur_ff, cur_in, t_ff, t_in;
   logic [NextAw:0] clr_ff, clr_in;
   logic [NW-1:0] n_ff [Symbols];
   logic [NW-1:0] n_in [Symbols];
   logic [SymW-1:0] ej_ff, ej_in;

   logic set_we;
   logic [SetAw-1:0] set_wa, set_ra;
   mask_type set_rd_ff;
   logic nx_we;
   logic [NextAw-1:0] nx_wa, nx_ra;
   logic [NW-1:0] nx_wd, nx_rd_ff;
   logic [2:0] eff_c;

   always_ff @(posedge clock) begin
      if (set_we) set_mem[set_wa] <= t_ff;
      set_rd_ff <= set_mem[set_ra];
      if (nx_we) next_mem[nx_wa] <= nx_wd;
      nx_rd_ff <= next_mem[nx_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         wp_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
      end
      fi_ff <= fi_in; c_ff <= c_in; eff_ff <= eff_in; ovf_ff <= ovf_in;
      clos_ff <= clos_in; phase_ff <= phase_in; cur_ff <= cur_in; t_ff <= t_in;
      clr_ff <= clr_in; ej_ff <= ej_in;
      for (int j = 0; j < Symbols; j++) n_ff[j] <= n_in[j];
   end

   assign eff_c = (symbol_count > 3'(Symbols)) ? 3'(Symbols) : symbol_count;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (run) state_in = ST_CLEAR;
         ST_CLEAR:     if (clr_ff == (NextAw+1)'(NextDepth)) state_in = ST_MOVE;
         ST_MOVE:      state_in = ST_MOVE_WAIT;
         ST_MOVE_WAIT: if (mv_rsp.done) state_in = ST_CLOS_CHK;
         ST_CLOS_CHK:  state_in = ST_FIND;
         ST_FIND:      state_in = ST_FIND_WAIT;
         ST_FIND_WAIT: state_in = ST_STORE;
         ST_STORE:     state_in = ST_NEXT_SYM;
         ST_NEXT_SYM:  state_in = ST_NEXT_SYM;
         ST_EMIT_RD:   state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: state_in = ST_EMIT;
         ST_EMIT:      state_in = ST_EMIT;
         default:      state_in = ST_IDLE;
      endcase
      // data-dependent transitions resolved in the output block
      if (state_ff == ST_CLOS_CHK || state_ff == ST_FIND_WAIT || state_ff == ST_STORE ||
          state_ff == ST_NEXT_SYM || state_ff == ST_EMIT || state_ff == ST_MOVE_WAIT ||
          state_ff == ST_EMIT_WAIT)
         state_in = st_sel;
   end

   // datapath and outputs
   always_comb begin
      st_sel = state_ff;
      cnt_in = cnt_ff; wp_in = wp_ff; fi_in = fi_ff; c_in = c_ff; eff_in = eff_ff;
      ovf_in = ovf_ff; clos_in = clos_ff; phase_in = phase_ff; cur_in = cur_ff;
      t_in = t_ff; clr_in = clr_ff; ej_in = ej_ff;
      for (int j = 0; j < Symbols; j++) n_in[j] = n_ff[j];
      set_we = 1'b0; set_wa = cnt_ff[SetAw-1:0]; set_ra = '0;
      nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
      mv_req = '0;
      case (state_ff)
         ST_IDLE: begin
            clr_in = '0;
            eff_in = SymW'(eff_c);
            ovf_in = 1'b0;
            cnt_in = '0;
            wp_in = '0;
            clos_in = 1'b1; // first pass: closure of start
            phase_in = 1'b0;
            cur_in = (start_state >= 5'd1 && start_state <= 5'(NfaStates))
                     ? mask_type'(1) << (start_state - 5'd1) : '0;
         end
         ST_CLEAR: begin
            nx_we = 1'b1;
            nx_wa = clr_ff[NextAw-1:0];
            clr_in = clr_ff + 1'b1;
         end
         ST_MOVE: begin
            mv_req.start = 1'b1;
            mv_req.set = clos_ff ? t_ff : cur_ff;
            if (cnt_ff == '0 && !phase_ff) mv_req.set = cur_ff;
            mv_req.col = c_ff;
            mv_req.closure = clos_ff;
         end
         ST_MOVE_WAIT: begin
            if (mv_rsp.done) begin
               t_in = mv_rsp.result;
               st_sel = ST_CLOS_CHK;
            end
         end
         ST_CLOS_CHK: begin
            if (cnt_ff == '0) begin
               // start set stored as DFA state 1
               set_we = 1'b1;
               set_wa = '0;
               cnt_in = CntW'(1);
               wp_in = '0;
               st_sel = ST_NEXT_SYM;
               c_in = '0;
               phase_in = 1'b1;
            end else if (!clos_ff) begin
               if (t_ff == '0) begin
                  c_in = c_ff + 1'b1;
                  st_sel = ST_NEXT_SYM;
               end else begin
                  clos_in = 1'b1;
                  st_sel = ST_MOVE;
               end
            end else begin
               fi_in = '0;
               st_sel = ST_FIND;
            end
         end
         ST_FIND: begin
            set_ra = fi_ff[SetAw-1:0];
         end
         ST_FIND_WAIT: begin
            set_ra = fi_ff[SetAw-1:0];
            st_sel = ST_STORE;
         end
         ST_STORE: begin
            nx_wa = NextAw'(wp_ff[SetAw-1:0] * Symbols + c_ff);
            if (set_rd_ff == t_ff) begin
               nx_we = 1'b1;
               nx_wd = NW'(fi_ff + 1'b1);
               c_in = c_ff + 1'b1;
               st_sel = ST_NEXT_SYM;
            end else if (fi_ff + 1'b1 < cnt_ff) begin
               fi_in = fi_ff + 1'b1;
               st_sel = ST_FIND;
            end else if (cnt_ff >= CntW'(DfaStates)) begin
               ovf_in = 1'b1;
               fi_in = '0;
               st_sel = ST_EMIT_RD;
            end else begin
               set_we = 1'b1;
               set_wa = cnt_ff[SetAw-1:0];
               nx_we = 1'b1;
               nx_wd = NW'(cnt_ff + 1'b1);
               cnt_in = cnt_ff + 1'b1;
               c_in = c_ff + 1'b1;
               st_sel = ST_NEXT_SYM;
            end
         end
         ST_NEXT_SYM: begin
            set_ra = wp_ff[SetAw-1:0];
            clos_in = 1'b0;
            if (c_ff < eff_ff && wp_ff < cnt_ff) begin
               st_sel = ST_FIND_WAIT;
               // the current set is read out for FIND_WAIT
               phase_in = 1'b1;
            end else begin
               if (c_ff != '0 || eff_ff == '0) wp_in = wp_ff + 1'b1;
               c_in = '0;
               if (wp_ff + ((c_ff != '0 || eff_ff == '0) ? 1'b1 : 1'b0) >= cnt_ff) begin
                  fi_in = '0;
                  st_sel = ST_EMIT_RD;
               end else begin
                  st_sel = ST_NEXT_SYM;
                  if (eff_ff == '0) st_sel = ST_NEXT_SYM;
               end
               // when c wraps with eff==0 and no more work, handled above
               if (eff_ff != '0 && c_ff == '0 && wp_ff < cnt_ff) st_sel = ST_FIND_WAIT;
            end
         end
         ST_EMIT_RD: begin
            set_ra = fi_ff[SetAw-1:0];
            nx_ra = NextAw'(fi_ff[SetAw-1:0] * Symbols);
            ej_in = '0;
         end
         ST_EMIT_WAIT: begin
            // gather successors one per cycle
            nx_ra = NextAw'(fi_ff[SetAw-1:0] * Symbols + ej_ff + 1'b1);
            set_ra = fi_ff[SetAw-1:0];
            cur_in = set_rd_ff;
            n_in[ej_ff[$clog2(Symbols)-1:0]] = (ej_ff < eff_ff) ? nx_rd_ff : '0;
            ej_in = ej_ff + 1'b1;
            if (ej_ff + 1'b1 < SymW'(Symbols)) st_sel = ST_EMIT_WAIT;
            else st_sel = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               fi_in = fi_ff + 1'b1;
               if (fi_ff + 1'b1 >= cnt_ff) st_sel = ST_IDLE;
               else st_sel = ST_EMIT_RD;
            end
         end
         default: ;
      endcase
      // a FIND_WAIT reached from NEXT_SYM means the current set was just read
      if (state_ff == ST_FIND_WAIT && !clos_ff && phase_ff) begin
         cur_in = set_rd_ff;
         st_sel = ST_MOVE;
         phase_in = 1'b0;
      end else if (state_ff == ST_FIND_WAIT) begin
         st_sel = ST_STORE;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp.valid = (state_ff == ST_EMIT);
   assign rsp.row_index = 7'(fi_ff + 1'b1);
   assign rsp.member_mask = cur_ff;
   assign rsp.next_sym0 = 7'(n_ff[0]);
   assign rsp.next_sym1 = 7'(n_ff[1]);
   assign rsp.next_sym2 = 7'(n_ff[2]);
   assign rsp.next_sym3 = 7'(n_ff[3]);
   assign rsp.is_final = |(cur_ff & final_mask);
   assign rsp.overflow = ovf_ff;
   assign rsp.last = (fi_ff + 1'b1 >= cnt_ff);

   `N2D_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CntW'(DfaStates))
   `N2D_ASSERT_IMPL(a_emit_in_range, clock, reset, rsp.valid, fi_ff < cnt_ff)
   `N2D_ASSERT_NEXT(a_emit_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
endmodule

// ===== rtl/nfa_to_dfa_subset_construction_top.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Handshake     | Payload
// req     | in  | valid/ready   | op, from_state, symbol, target_mask
// rsp     | out | valid/ready   | row_index, member_mask, next_sym0..3, is_final, overflow, last
// csr     | in  | write enable  | csr_index, csr_data
// A run clears the successor memory, then each move or closure pass scans the 16 NFA
// states one per cycle on the edge-memory read port; set search compares one stored
// set per FIND, FIND_WAIT, STORE pass. Rows emit through EMIT_RD, EMIT_WAIT and EMIT.
// Synchronous active-high reset clears the edge store validity; ready is low during a run.
module nfa_to_dfa_subset_construction_top
   import n2d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   n2d_req_if.sink     req,
   n2d_rsp_if.source   rsp
);
   logic [4:0] start_ff;
   mask_type   final_ff;
   logic [2:0] symcnt_ff;
   logic       busy;
   logic       ld_ok;
   mv_req_type mv_req;
   mv_rsp_type mv_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 5'd1;
         final_ff <= '0;
         symcnt_ff <= 3'd4;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START:  start_ff <= csr_data[4:0];
            CSR_FINAL:  final_ff <= csr_data;
            CSR_SYMCNT: symcnt_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign req.ready = !busy;
   assign ld_ok = req.valid && req.ready && !req.op && req.from_state >= 5'd1 &&
                  req.from_state <= 5'(NfaStates) && req.symbol <= 3'(Symbols);

   n2d_move u_move (
      .clock, .reset,
      .wr_en(ld_ok),
      .wr_addr(EdgeAw'((req.from_state - 5'd1) * Cols + req.symbol)),
      .wr_data(req.target_mask),
      .req(mv_req),
      .rsp(mv_rsp)
   );

   n2d_seq u_seq (
      .clock, .reset,
      .run(req.valid && req.ready && req.op),
      .busy,
      .start_state(start_ff),
      .final_mask(final_ff),
      .symbol_count(symcnt_ff),
      .mv_req, .mv_rsp,
      .rsp
   );
endmodule
